@@ rtl/core/binary_search_table_defines.svh @@
// Assertion macros shared by the table logic.
`ifndef BINARY_SEARCH_TABLE_DEFINES_SVH
`define BINARY_SEARCH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BST_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bst_pkg.sv @@
package bst_pkg;

	localparam int OP_W  = 1;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int CNT_W = 11;

	localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
	localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_STEP
	} bst_state_t;

endpackage

@@ rtl/core/bst_ifs.sv @@
interface bst_item_if;
	import bst_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [IDX_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] entry_value;
	logic signed [VAL_W-1:0] search_value;

	modport source (output valid, operation, entry_index, entry_value, search_value,
		input ready);
	modport sink (input valid, operation, entry_index, entry_value, search_value,
		output ready);
endinterface

interface bst_result_if;
	import bst_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] match_index;

	modport source (output valid, found, match_index, input ready);
	modport sink (input valid, found, match_index, output ready);
endinterface

@@ rtl/core/binary_search_table.sv @@
// Sorted table of signed 32-bit entries with binary search.
// item channel: operation selects a write (entry_value into entry_index) or a
// search for search_value. result channel: one transaction per search, none per
// write; found with match_index, or found low and match_index zero.
// entry_count (write enable plus data) sets how many entries from index zero
// are searched; values above TABLE_DEPTH search the whole table. Change it only
// while no search is in flight.
// A search makes p probes before its result is registered, p at most
// floor(log2(count)) + 1 (11 at 1024 entries); one probe per cycle, set by the
// registered read of the table memory feeding the compare and the next address.
// Items are taken only between searches. A finished result sits in an output
// register; a new item is accepted while it waits, and a search whose result is
// ready holds until that register frees up.
// Reset clears entry_count and the control state; table contents are undefined
// until written, and searches must only reach written entries.
module binary_search_table #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	bst_item_if.sink                  item,
	bst_result_if.source              result,
	input  logic                      entry_count_we,
	input  logic [bst_pkg::CNT_W-1:0] entry_count_wdata
);
	import bst_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [CNT_W-1:0] entry_count_q;
	logic [CW-1:0]    count;

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (entry_count_we) begin
			entry_count_q <= entry_count_wdata;
		end
	end

	always_comb begin
		if (int'(entry_count_q) > TABLE_DEPTH) begin
			count = CW'(TABLE_DEPTH);
		end else begin
			count = CW'(entry_count_q);
		end
	end

	bst_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.count     (count),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bst_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ rtl/core/bst_table_mem.sv @@
module bst_table_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [bst_pkg::VAL_W-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [bst_pkg::VAL_W-1:0]  rdata
);
	import bst_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bst_engine.sv @@
`include "binary_search_table_defines.svh"

module bst_engine #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	bst_item_if.sink                  item,
	bst_result_if.source              result,
	input  logic [CW-1:0]             count,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [bst_pkg::VAL_W-1:0] mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  logic [bst_pkg::VAL_W-1:0] mem_rdata
);
	import bst_pkg::*;

	bst_state_t state_q, state_d;

	logic signed [VAL_W-1:0] target_q;
	logic [CW-1:0]           low_q, hi_q;
	logic [AW-1:0]           mid_q;
	logic                    pend_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [IDX_W-1:0]        match_q;

	logic signed [VAL_W-1:0] probe;
	logic [CW-1:0]           nlow, nhi, mid_inc;
	logic [CW:0]             sum;
	logic [AW-1:0]           nmid;
	logic                    eq, empty;
	logic                    start, finish, out_free, load_res;

	assign probe   = $signed(mem_rdata);
	assign mid_inc = CW'(mid_q) + CW'(1);

	// narrowing of [low, hi) and the next midpoint
	always_comb begin
		eq   = 1'b0;
		nlow = low_q;
		nhi  = hi_q;
		if (state_q == ST_IDLE) begin
			nlow = '0;
			nhi  = count;
		end else if (pend_q) begin
			if (target_q == probe) begin
				eq = 1'b1;
			end else if (target_q > probe) begin
				nlow = mid_inc;
			end else begin
				nhi = CW'(mid_q);
			end
		end
		empty = (nlow >= nhi);
		sum   = {1'b0, nlow} + {1'b0, nhi} - (CW + 1)'(1);
		nmid  = sum[AW:1];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = (state_q == ST_IDLE);
		start      = item.valid && (state_q == ST_IDLE) && (item.operation == OP_SEARCH);
		finish     = (state_q == ST_STEP) && (eq || empty);
		out_free   = !out_valid_q || result.ready;
		load_res   = finish && out_free;
		mem_we     = item.valid && (state_q == ST_IDLE) && (item.operation == OP_WRITE)
			&& (int'(item.entry_index) < TABLE_DEPTH);
		mem_waddr  = AW'(item.entry_index);
		mem_wdata  = item.entry_value;
		mem_re     = (start && !empty) || ((state_q == ST_STEP) && !finish);
		mem_raddr  = nmid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				pend_q <= !empty;
			end else if (load_res) begin
				pend_q <= 1'b0;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			target_q <= item.search_value;
		end
		if (start || ((state_q == ST_STEP) && !finish)) begin
			low_q <= nlow;
			hi_q  <= nhi;
			mid_q <= nmid;
		end
		if (load_res) begin
			found_q <= eq;
			match_q <= eq ? IDX_W'(mid_q) : '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = found_q;
	assign result.match_index = match_q;

	`BST_ASSERT_IMPL(a_no_rw_overlap, mem_we, !mem_re, "table read and write in one cycle")
	`BST_ASSERT_IMPL(a_pend_in_step, pend_q, state_q == ST_STEP, "probe pending outside search")
	`BST_ASSERT_IMPL(a_range_order, state_q == ST_STEP, low_q <= hi_q, "search range inverted")
	`BST_ASSERT_IMPL(a_mid_in_range, pend_q, (CW'(mid_q) >= low_q) && (CW'(mid_q) < hi_q),
		"probe outside search range")
	`BST_ASSERT_NEXT(a_result_loaded, load_res, out_valid_q, "finished search lost")

endmodule

@@ test/binary_search_table_test.sv @@
module binary_search_table_test;
	import bst_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int SETTLE = 16;
	localparam int RANDOM_ITEMS = 220;
	localparam int VMIN = 32'sh8000_0000;
	localparam int VMAX = 32'sh7fff_ffff;
	localparam int NUM_ROWS = 23;
	localparam int COUNT_TOP = 2047;

	typedef enum logic {
		ROW_ITEM,
		ROW_COUNT
	} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic [OP_W-1:0] op;
		int              at;
		int              value;
		bit              typed;
		bit              hit;
		int              hit_at;
	} row_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] index;
	} lookup_t;

	logic clk;
	logic arst_n;
	logic entry_count_we;
	logic [CNT_W-1:0] entry_count_wdata;

	bst_item_if   item_ch();
	bst_result_if res_ch();

	binary_search_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (item_ch),
		.result           (res_ch),
		.entry_count_we   (entry_count_we),
		.entry_count_wdata(entry_count_wdata)
	);

	logic signed [VAL_W-1:0] bank [TABLE_DEPTH];
	bit filled [TABLE_DEPTH];
	logic [CNT_W-1:0] cur_count;
	lookup_t lookups_due [$];
	bit steady;
	int failures;
	int items_sent;
	int searches;
	int hits;

	// counts 0 and 1, both value extremes, equal entries, misses, an unsorted table
	row_t plan [NUM_ROWS] = '{
		'{ROW_ITEM,  OP_SEARCH, 0, 5,    1'b1, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  0, VMIN, 1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  1, -1,   1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  2, 0,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  3, 7,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  4, 7,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  5, VMAX, 1'b0, 1'b0, 0},
		'{ROW_COUNT, OP_WRITE,  0, 6,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, VMIN, 1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, VMAX, 1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, -1,   1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, 7,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, 3,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, VMAX - 1, 1'b0, 1'b0, 0},
		'{ROW_COUNT, OP_WRITE,  0, 1,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, VMIN, 1'b1, 1'b1, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, 0,    1'b1, 1'b0, 0},
		'{ROW_ITEM,  OP_WRITE,  2, 100,  1'b0, 1'b0, 0},
		'{ROW_COUNT, OP_WRITE,  0, 6,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, 0,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, 100,  1'b0, 1'b0, 0},
		'{ROW_COUNT, OP_WRITE,  0, 0,    1'b0, 1'b0, 0},
		'{ROW_ITEM,  OP_SEARCH, 0, VMIN, 1'b1, 1'b0, 0}
	};

	function automatic lookup_t bisect_lookup(input logic signed [VAL_W-1:0] target);
		int lo;
		int hi;
		int mid;
		lookup_t r;
		r = '0;
		lo = 0;
		hi = ((cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count)) - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (target == bank[mid]) begin
				r.found = 1'b1;
				r.index = mid[IDX_W-1:0];
				return r;
			end
			if (target > bank[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return r;
	endfunction

	task automatic issue(input logic [OP_W-1:0] op, input int at, input int value,
		input bit typed, input bit hit, input int hit_at);
		lookup_t due;
		while (!steady && $urandom_range(0, 99) < 29) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.operation    <= op;
		item_ch.entry_index  <= at[IDX_W-1:0];
		item_ch.entry_value  <= (op == OP_WRITE) ? value : $urandom;
		item_ch.search_value <= (op == OP_SEARCH) ? value : $urandom;
		do @(negedge clk); while (item_ch.ready !== 1'b1);
		@(posedge clk);
		items_sent++;
		if (op == OP_WRITE) begin
			bank[at] = value;
			filled[at] = 1'b1;
		end else begin
			if (typed) begin
				due.found = hit;
				due.index = hit_at[IDX_W-1:0];
			end else begin
				due = bisect_lookup(value);
			end
			lookups_due = {lookups_due, due};
			searches++;
		end
	endtask

	task automatic set_count(input int n);
		item_ch.valid <= 1'b0;
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		entry_count_we    <= 1'b1;
		entry_count_wdata <= n[CNT_W-1:0];
		@(posedge clk);
		entry_count_we <= 1'b0;
		cur_count = n[CNT_W-1:0];
	endtask

	task automatic load_entries(input int n);
		int vals [$];
		int spread;
		spread = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			case (spread)
				0: vals = {vals, $urandom};
				1: vals = {vals, $urandom_range(0, 15) - 8};
				default: vals = {vals, $urandom_range(0, 4000) - 2000};
			endcase
		end
		if ($urandom_range(0, 9) != 0)
			vals.sort();
		for (int i = 0; i < n; i++)
			issue(OP_WRITE, i, vals[i], 1'b0, 1'b0, 0);
	endtask

	// only entries below the active span are rewritten or probed
	task automatic probe_round(input int n, input int m);
		int span;
		int pick;
		int target;
		span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
		for (int k = 0; k < m; k++) begin
			pick = $urandom_range(0, 99);
			if (span > 0 && pick < 8) begin
				issue(OP_WRITE, $urandom_range(0, span - 1), $urandom, 1'b0, 1'b0, 0);
				continue;
			end
			if (span > 0 && pick < 60)
				target = bank[$urandom_range(0, span - 1)];
			else if (span > 0 && pick < 75)
				target = bank[$urandom_range(0, span - 1)] + ($urandom_range(0, 1) ? 1 : -1);
			else if (pick < 90)
				target = $urandom;
			else
				target = $urandom_range(0, 1) ? VMIN : VMAX;
			issue(OP_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), target, 1'b0, 1'b0, 0);
		end
	endtask

	// writes every unwritten entry on the probe path of target, with values that rise with the index
	task automatic fill_path(input int n, input int target, output int last);
		int lo;
		int hi;
		int mid;
		logic [IDX_W-1:0] slot;
		last = 0;
		lo = 0;
		hi = ((n > TABLE_DEPTH) ? TABLE_DEPTH : n) - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			last = mid;
			if (!filled[mid]) begin
				slot = mid[IDX_W-1:0];
				issue(OP_WRITE, mid,
					{~slot[IDX_W-1], slot[IDX_W-2:0], (VAL_W - IDX_W)'($urandom)},
					1'b0, 1'b0, 0);
			end
			if (target == bank[mid])
				break;
			if (target > bank[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
	endtask

	task automatic deep_round(input int n, input int m);
		int pick;
		int target;
		int last;
		for (int k = 0; k < m; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				target = $urandom_range(0, 1) ? VMIN : VMAX;
			else
				target = $urandom;
			fill_path(n, target, last);
			if (pick >= 40) begin
				target = bank[last] + ((pick < 55) ? 1 : 0);
				fill_path(n, target, last);
			end
			issue(OP_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), target, 1'b0, 1'b0, 0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	always @(negedge clk) begin
		lookup_t due;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (lookups_due.size() == 0) begin
				$error("unexpected result transaction: found %0b match_index %0d",
					res_ch.found, res_ch.match_index);
				failures++;
			end else begin
				due = lookups_due.pop_front();
				if (res_ch.found !== due.found) begin
					$error("found: expected %0b, got %0b", due.found, res_ch.found);
					failures++;
				end
				if (res_ch.match_index !== due.index) begin
					$error("match_index: expected %0d, got %0d", due.index, res_ch.match_index);
					failures++;
				end
				if (res_ch.found === 1'b1)
					hits++;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int pick;
		int n;
		item_ch.valid        <= 1'b0;
		item_ch.operation    <= OP_WRITE;
		item_ch.entry_index  <= '0;
		item_ch.entry_value  <= '0;
		item_ch.search_value <= '0;
		entry_count_we       <= 1'b0;
		entry_count_wdata    <= '0;
		arst_n               <= 1'b0;
		cur_count = '0;
		steady = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_COUNT)
				set_count(plan[i].value);
			else
				issue(plan[i].op, plan[i].at, plan[i].value, plan[i].typed, plan[i].hit,
					plan[i].hit_at);
		end

		while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				n = 0;
			else if (pick < 20)
				n = $urandom_range(1, 3);
			else if (pick < 88)
				n = $urandom_range(4, 40);
			else
				n = $urandom_range(41, 200);
			set_count(n);
			load_entries(n);
			probe_round(n, $urandom_range(5, 30));
		end

		// full depth, no idling on either side in the first deep round; then counts above TABLE_DEPTH
		steady = 1'b1;
		set_count(TABLE_DEPTH);
		deep_round(TABLE_DEPTH, 16);
		steady = 1'b0;
		set_count(COUNT_TOP);
		deep_round(COUNT_TOP, 8);
		n = $urandom_range(TABLE_DEPTH + 1, COUNT_TOP - 1);
		set_count(n);
		deep_round(n, 8);

		item_ch.valid <= 1'b0;
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (lookups_due.size() != 0) begin
			$error("%0d searches never answered", lookups_due.size());
			failures++;
		end
		$display("%0d item transactions, %0d searches, %0d found", items_sent, searches, hits);
		$display("entry_count from 0 up to %0d, full-depth searches on filled probe paths",
			COUNT_TOP);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
